/* rtl/lmnf_pkg.sv */
// shared types, constants and helper functions for the list marker formatter
package lmnf_pkg;

    localparam int ITEM_W         = 10;
    localparam int CHAR_W         = 11;
    localparam int STYLE_W        = 3;
    localparam int CNT_W          = 6;
    localparam int VALUE_BITS_DEF = 10;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic [STYLE_W-1:0] STYLE_DECIMAL  = 3'd0;
    localparam logic [STYLE_W-1:0] STYLE_ROMAN_LO = 3'd1;
    localparam logic [STYLE_W-1:0] STYLE_ROMAN_UP = 3'd2;
    localparam logic [STYLE_W-1:0] STYLE_GREEK    = 3'd3;
    localparam logic [STYLE_W-1:0] STYLE_HEBREW   = 3'd4;
    localparam logic [STYLE_W-1:0] STYLE_LATIN_LO = 3'd5;
    localparam logic [STYLE_W-1:0] STYLE_LATIN_UP = 3'd6;

    localparam logic [CHAR_W-1:0] CH_SPACE    = 11'd32;
    localparam logic [CHAR_W-1:0] CH_APOS     = 11'd39;
    localparam logic [CHAR_W-1:0] CH_DOT      = 11'd46;
    localparam logic [CHAR_W-1:0] CH_ZERO     = 11'd48;
    localparam logic [CHAR_W-1:0] CH_LAT_UP   = 11'd65;
    localparam logic [CHAR_W-1:0] CH_LAT_LO   = 11'd97;
    localparam logic [CHAR_W-1:0] CH_ALPHA    = 11'd945;
    localparam logic [CHAR_W-1:0] CH_ALEF     = 11'd1488;
    localparam logic [CHAR_W-1:0] CH_TET      = 11'd1496;
    localparam logic [CHAR_W-1:0] CH_HUND0    = 11'd1510;
    localparam logic [CHAR_W-1:0] CH_TAV      = 11'd1514;

    typedef enum logic [1:0] {
        F_IDLE,
        F_DIV,
        F_REM,
        F_PUSH
    } t_fstate;

    typedef enum logic [2:0] {
        B_IDLE,
        B_THOU,
        B_HUND,
        B_TENS,
        B_UNIT,
        B_DOT,
        B_SPACE
    } t_bstate;

    typedef struct packed {
        logic [STYLE_W-1:0] style;
        logic               zero;
        logic               d1000;
        logic [3:0]         hund;
        logic [3:0]         tens;
        logic [3:0]         units;
        logic [4:0]         letter;
        logic [CNT_W-1:0]   passes;
    } t_desc;

    function automatic logic [CHAR_W-1:0] roman_sym(input logic upper, input logic [3:0] idx);
        logic [CHAR_W-1:0] c;
        case (idx)
            4'd0:    c = 11'd105;
            4'd1:    c = 11'd118;
            4'd2:    c = 11'd120;
            4'd3:    c = 11'd108;
            4'd4:    c = 11'd99;
            4'd5:    c = 11'd100;
            default: c = 11'd109;
        endcase
        return upper ? c - 11'd32 : c;
    endfunction

    function automatic logic [3:0] roman_rest(input logic [3:0] d);
        return (d >= 4'd5) ? d - 4'd5 : d;
    endfunction

    function automatic logic [CNT_W-1:0] roman_len(input logic [3:0] d);
        logic [3:0] r;
        r = roman_rest(d);
        if (r == 4'd4) begin
            return CNT_W'(2);
        end
        return CNT_W'(r) + CNT_W'(d >= 4'd5);
    endfunction

    function automatic logic [CHAR_W-1:0] roman_char(input logic upper, input logic [3:0] pos,
                                                     input logic [3:0] d, input logic [1:0] j);
        logic [3:0] r;
        logic [3:0] idx;
        r = roman_rest(d);
        if (r == 4'd4) begin
            idx = (j == 2'd0) ? pos : ((d == 4'd9) ? pos + 4'd2 : pos + 4'd1);
        end else if (d >= 4'd5 && j == 2'd0) begin
            idx = pos + 4'd1;
        end else begin
            idx = pos;
        end
        return roman_sym(upper, idx);
    endfunction

    function automatic logic [CHAR_W-1:0] hebrew_tens(input logic [3:0] t);
        logic [CHAR_W-1:0] c;
        case (t)
            4'd1:    c = 11'd1497;
            4'd2:    c = 11'd1499;
            4'd3:    c = 11'd1500;
            4'd4:    c = 11'd1502;
            4'd5:    c = 11'd1504;
            4'd6:    c = 11'd1505;
            4'd7:    c = 11'd1506;
            4'd8:    c = 11'd1508;
            default: c = 11'd1510;
        endcase
        return c;
    endfunction

    // tens digit of a value below one hundred
    function automatic logic [3:0] tens_of(input logic [6:0] x);
        return (x >= 7'd90) ? 4'd9 : (x >= 7'd80) ? 4'd8 : (x >= 7'd70) ? 4'd7 :
               (x >= 7'd60) ? 4'd6 : (x >= 7'd50) ? 4'd5 : (x >= 7'd40) ? 4'd4 :
               (x >= 7'd30) ? 4'd3 : (x >= 7'd20) ? 4'd2 : (x >= 7'd10) ? 4'd1 : 4'd0;
    endfunction

endpackage

/* rtl/lmnf_in_if.sv */
// input channel: one item number per transaction
interface lmnf_in_if;
    import lmnf_pkg::*;
    logic              valid;
    logic              ready;
    logic [ITEM_W-1:0] item_number;
    modport source (output valid, output item_number, input ready);
    modport sink (input valid, input item_number, output ready);
endinterface

/* rtl/lmnf_out_if.sv */
// output channel: one marker character per transaction
interface lmnf_out_if;
    import lmnf_pkg::*;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_code;
    logic              last_char;
    modport source (output valid, output char_code, output last_char, input ready);
    modport sink (input valid, input char_code, input last_char, output ready);
endinterface

/* rtl/lmnf_front.sv */
// front end: accepts an item and splits it into digits, letter and pass count
module lmnf_front
    import lmnf_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [STYLE_W-1:0] i_style,
    lmnf_in_if.sink            i_item,
    input  logic               i_full,
    output logic               o_push,
    output t_desc              o_desc
);

    t_fstate r_state, n_state;

    logic [VALUE_BITS-1:0] r_v;
    logic [STYLE_W-1:0]    r_style;
    logic                  r_zero;
    logic                  r_d1000;
    logic [ITEM_W-1:0]     r_w;
    logic [3:0]            r_h;
    logic [ITEM_W-1:0]     r_k;
    logic [CNT_W-1:0]      r_q24;
    logic [CNT_W-1:0]      r_q26;
    logic [6:0]            r_t2;
    logic [4:0]            r_l24;
    logic [4:0]            r_l26;

    logic [ITEM_W-1:0] v10;
    logic              d1000;
    logic [ITEM_W-1:0] w;
    logic [ITEM_W-1:0] k;
    logic [15:0]       p_h;
    logic [14:0]       p24;
    logic [18:0]       p26;
    logic [3:0]        tens;
    logic [3:0]        units;
    logic [4:0]        l24;
    logic              accept;

    assign accept = i_item.valid && i_item.ready;

    // division by constants through reciprocal multiplies, exact over the value range
    assign v10   = ITEM_W'(r_v);
    assign d1000 = (v10 >= ITEM_W'(1000));
    assign w     = d1000 ? v10 - ITEM_W'(1000) : v10;
    assign k     = v10 - ITEM_W'(1);
    assign p_h   = 16'(w) * 16'd41;
    assign p24   = 15'(k[ITEM_W-1:3]) * 15'd171;
    assign p26   = 19'(k[ITEM_W-1:1]) * 19'd631;

    assign tens  = tens_of(r_t2);
    assign units = 4'(r_t2 - 7'(tens) * 7'd10);
    // greek skips final sigma
    assign l24   = (r_l24 > 5'd16) ? r_l24 + 5'd1 : r_l24;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE: begin
                if (accept) begin
                    n_state = F_DIV;
                end
            end
            F_DIV:  n_state = F_REM;
            F_REM:  n_state = F_PUSH;
            F_PUSH: begin
                if (!i_full) begin
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_comb begin
        i_item.ready = (r_state == F_IDLE);
        o_push       = (r_state == F_PUSH) && !i_full;
        o_desc.style  = r_style;
        o_desc.zero   = r_zero;
        o_desc.d1000  = r_d1000;
        o_desc.hund   = r_h;
        o_desc.tens   = tens;
        o_desc.units  = units;
        if (r_style == STYLE_GREEK) begin
            o_desc.letter = l24;
            o_desc.passes = r_q24;
        end else begin
            o_desc.letter = r_l26;
            o_desc.passes = r_q26;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_v     <= i_item.item_number[VALUE_BITS-1:0];
            r_style <= i_style;
        end
        if (r_state == F_DIV) begin
            r_zero  <= (v10 == '0);
            r_d1000 <= d1000;
            r_w     <= w;
            r_h     <= p_h[15:12];
            r_k     <= k;
            r_q24   <= p24[14:9];
            r_q26   <= p26[18:13];
        end
        if (r_state == F_REM) begin
            r_t2  <= 7'(r_w - ITEM_W'(r_h) * ITEM_W'(100));
            r_l24 <= 5'(r_k - ITEM_W'(r_q24) * ITEM_W'(24));
            r_l26 <= 5'(r_k - ITEM_W'(r_q26) * ITEM_W'(26));
        end
    end

endmodule

/* rtl/lmnf_queue.sv */
// small descriptor queue between front and back
module lmnf_queue
    import lmnf_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_desc i_desc,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_empty,
    output t_desc o_desc
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_Q = $clog2(DEPTH + 1);

    t_desc              r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr, r_rd;
    logic [CNT_Q-1:0]   r_cnt;

    assign o_full  = (r_cnt == CNT_Q'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_desc  = r_mem[r_rd];

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= bump(r_wr);
            end
            if (i_pop) begin
                r_rd <= bump(r_rd);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CNT_Q'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - CNT_Q'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_desc;
        end
    end

endmodule

/* rtl/lmnf_back.sv */
// back end: walks the marker slots and sends one character per transaction
module lmnf_back
    import lmnf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_empty,
    input  t_desc      i_desc,
    output logic       o_pop,
    lmnf_out_if.source o_char
);

    t_bstate r_state, n_state;

    t_desc             r_desc;
    logic [CNT_W-1:0]  r_j;
    logic              r_out_valid;
    logic [CHAR_W-1:0] r_char;
    logic              r_last;

    logic              can;
    logic              slot;
    logic [CNT_W-1:0]  slot_len;
    logic [CHAR_W-1:0] slot_char;
    logic              slot_end;
    logic              emit;
    logic [CHAR_W-1:0] emit_char;
    logic [3:0]        dig;
    logic [3:0]        rpos;
    logic              hi_nz;
    logic              special;
    logic [1:0]        tav;

    assign can  = !r_out_valid || o_char.ready;
    assign slot = (r_state == B_THOU) || (r_state == B_HUND) ||
                  (r_state == B_TENS) || (r_state == B_UNIT);
    assign slot_end = (slot_len == '0) || (r_j == slot_len - CNT_W'(1));

    always_comb begin
        hi_nz   = r_desc.d1000 || (r_desc.hund != 4'd0);
        special = (r_desc.tens == 4'd1) && ((r_desc.units == 4'd5) || (r_desc.units == 4'd6));
        tav     = r_desc.hund[3:2];
        case (r_state)
            B_THOU:  begin dig = {3'd0, r_desc.d1000}; rpos = 4'd6; end
            B_HUND:  begin dig = r_desc.hund;           rpos = 4'd4; end
            B_TENS:  begin dig = r_desc.tens;           rpos = 4'd2; end
            default: begin dig = r_desc.units;          rpos = 4'd0; end
        endcase
        slot_len  = '0;
        slot_char = CH_SPACE;
        case (r_desc.style) inside
            STYLE_ROMAN_LO, STYLE_ROMAN_UP: begin
                slot_len  = roman_len(dig);
                slot_char = roman_char(r_desc.style == STYLE_ROMAN_UP, rpos, dig, r_j[1:0]);
            end
            STYLE_GREEK, STYLE_LATIN_LO, STYLE_LATIN_UP: begin
                if (r_state == B_THOU) begin
                    slot_len = CNT_W'(1);
                    if (r_desc.style == STYLE_GREEK) begin
                        slot_char = r_desc.zero ? CH_ALPHA - 11'd1
                                                : CH_ALPHA + CHAR_W'(r_desc.letter);
                    end else begin
                        slot_char = (r_desc.style == STYLE_LATIN_UP) ? CH_LAT_UP : CH_LAT_LO;
                        slot_char = r_desc.zero ? slot_char - 11'd1
                                                : slot_char + CHAR_W'(r_desc.letter);
                    end
                end else if (r_state == B_HUND) begin
                    // one apostrophe per full pass through the alphabet
                    slot_len  = r_desc.zero ? '0 : r_desc.passes;
                    slot_char = CH_APOS;
                end
            end
            STYLE_HEBREW: begin
                case (r_state)
                    B_THOU: begin
                        slot_len  = r_desc.d1000 ? CNT_W'(2) : '0;
                        slot_char = r_j[0] ? CH_APOS : CH_ALEF;
                    end
                    B_HUND: begin
                        slot_len  = CNT_W'(tav) + CNT_W'(r_desc.hund[1:0] != 2'd0);
                        slot_char = (r_j < CNT_W'(tav)) ? CH_TAV
                                                        : CH_HUND0 + CHAR_W'(r_desc.hund[1:0]);
                    end
                    B_TENS: begin
                        slot_len  = CNT_W'(special || (r_desc.tens != 4'd0));
                        slot_char = special ? CH_TET : hebrew_tens(r_desc.tens);
                    end
                    default: begin
                        // fifteen and sixteen are written tet plus vav or zayin
                        slot_len  = CNT_W'(special || (r_desc.units != 4'd0));
                        slot_char = special ? CH_ALEF + CHAR_W'(r_desc.units)
                                            : CH_ALEF - 11'd1 + CHAR_W'(r_desc.units);
                    end
                endcase
            end
            default: begin
                case (r_state)
                    B_THOU: begin
                        slot_len  = CNT_W'(r_desc.d1000);
                        slot_char = CH_ZERO + 11'd1;
                    end
                    B_HUND: begin
                        slot_len  = CNT_W'(hi_nz);
                        slot_char = CH_ZERO + CHAR_W'(r_desc.hund);
                    end
                    B_TENS: begin
                        // single digit gets a leading space
                        slot_len  = CNT_W'(1);
                        slot_char = (!hi_nz && r_desc.tens == 4'd0) ? CH_SPACE
                                                                   : CH_ZERO + CHAR_W'(r_desc.tens);
                    end
                    default: begin
                        slot_len  = CNT_W'(1);
                        slot_char = CH_ZERO + CHAR_W'(r_desc.units);
                    end
                endcase
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE: begin
                if (!i_empty) begin
                    n_state = B_THOU;
                end
            end
            B_THOU: if (can && slot_end) n_state = B_HUND;
            B_HUND: if (can && slot_end) n_state = B_TENS;
            B_TENS: if (can && slot_end) n_state = B_UNIT;
            B_UNIT: if (can && slot_end) n_state = B_DOT;
            B_DOT:  if (can) n_state = B_SPACE;
            B_SPACE: if (can) n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    always_comb begin
        o_pop     = (r_state == B_IDLE) && !i_empty;
        emit      = can && ((slot && slot_len != '0) || r_state == B_DOT || r_state == B_SPACE);
        emit_char = slot_char;
        if (r_state == B_DOT) begin
            emit_char = CH_DOT;
        end else if (r_state == B_SPACE) begin
            emit_char = CH_SPACE;
        end
        o_char.valid     = r_out_valid;
        o_char.char_code = r_char;
        o_char.last_char = r_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_j         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (can) begin
                r_out_valid <= emit;
                if (slot) begin
                    r_j <= slot_end ? '0 : r_j + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_desc <= i_desc;
        end
        if (emit) begin
            r_char <= emit_char;
            r_last <= (r_state == B_SPACE);
        end
    end

endmodule

/* rtl/list_marker_numeral_formatter_unit.sv */
// top level of the list marker formatter: style register, front, queue and back
//
//   channel   dir  handshake            payload
//   i_item    in   valid/ready          item_number[9:0]
//   o_char    out  valid/ready          char_code[10:0], last_char
//   cfg       in   i_cfg_we             i_cfg_wdata[2:0] numbering style
//
// one character leaves per cycle from the back end's slot walker while the output
// is not stalled; each digit slot takes a step even when it gives no character, and
// taking the next descriptor is a step of its own. the front end walks idle, divide,
// remainder and push for each item's digit split and waits in push while the queue
// is full. reset is synchronous and clears style, queue and state. a stalled output
// holds its register while the queue lets the front take the next item.
module list_marker_numeral_formatter_unit
    import lmnf_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [STYLE_W-1:0] i_cfg_wdata,
    lmnf_in_if.sink            i_item,
    lmnf_out_if.source         o_char
);

    logic [STYLE_W-1:0] r_style;
    logic               push;
    logic               full;
    logic               pop;
    logic               empty;
    t_desc              push_desc;
    t_desc              head_desc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_style <= STYLE_DECIMAL;
        end else if (i_cfg_we) begin
            r_style <= i_cfg_wdata;
        end
    end

    lmnf_front #(
        .VALUE_BITS(VALUE_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_style (r_style),
        .i_item  (i_item),
        .i_full  (full),
        .o_push  (push),
        .o_desc  (push_desc)
    );

    lmnf_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_desc  (push_desc),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_desc  (head_desc)
    );

    lmnf_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_desc  (head_desc),
        .o_pop   (pop),
        .o_char  (o_char)
    );

endmodule
